// ===== rtl/core/ptgd_pkg.sv =====
// Shared types, constants and the duty table builder for the temporal gray dither.
// No dependencies; used by ptgd_front, ptgd_back and the top level under rtl/core.
`default_nettype none

package ptgd_pkg;

   localparam int unsigned X_W       = 7;
   localparam int unsigned Y_W       = 6;
   localparam int unsigned LEVEL_W   = 3;
   localparam int unsigned PROFILE_W = 2;
   localparam int unsigned PHASE_W   = 6;
   localparam int unsigned PAGE_W    = 3;
   localparam int unsigned LEVELS    = 8;
   localparam int unsigned PROFILES  = 4;

   localparam int unsigned DISPLAY_WIDTH_DEF  = 128;
   localparam int unsigned DISPLAY_HEIGHT_DEF = 64;
   localparam int unsigned PHASE_COUNT_DEF    = 56;

   localparam int unsigned SEED_X_MUL  = 7;
   localparam int unsigned SEED_Y_MUL  = 11;
   localparam int unsigned SEED_OFFSET = 3;

   localparam int unsigned DUTY_ROUND   = 50;
   localparam int unsigned PERCENT_FULL = 100;

   localparam logic [PROFILE_W-1:0] PROFILE_LINEAR = 2'd0;
   localparam logic [PROFILE_W-1:0] PROFILE_BOOST  = 2'd1;
   localparam logic [PROFILE_W-1:0] PROFILE_TUNED  = 2'd2;

   localparam logic [LEVEL_W-1:0] LEVEL_WHITE = 3'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_BLACK = 3'd7;

   localparam logic [Y_W-1:0] STATUS_ROWS = 6'd8;

   localparam int unsigned CURVE_LIN   [LEVELS] = '{0, 14, 29, 43, 57, 71, 86, 100};
   localparam int unsigned CURVE_BOOST [LEVELS] = '{0, 22, 36, 50, 64, 79, 90, 100};
   localparam int unsigned CURVE_TUNED [LEVELS] = '{0, 13, 25, 38, 50, 63, 88, 100};

   typedef logic [PROFILES-1:0][LEVELS-1:0][PHASE_W-1:0] duty_table_type;

   typedef struct packed {
      logic              to_status_line;
      logic [PAGE_W-1:0] page_index;
      logic [2:0]        bit_index;
      logic [X_W-1:0]    column_out;
   } info_type;

   // Elaboration-time table: duty = (pct * pc + 50) / 100, ends forced.
   function automatic duty_table_type build_duty_table(input int unsigned pc);
      duty_table_type t;
      int unsigned    pct;
      t = '0;
      for (int p = 0; p < PROFILES; p++) begin
         for (int l = 0; l < LEVELS; l++) begin
            if (PROFILE_W'(p) == PROFILE_LINEAR) begin
               pct = CURVE_LIN[l];
            end else if (PROFILE_W'(p) == PROFILE_TUNED) begin
               pct = CURVE_TUNED[l];
            end else begin
               pct = CURVE_BOOST[l];
            end
            if (LEVEL_W'(l) == LEVEL_WHITE) begin
               t[p][l] = '0;
            end else if (LEVEL_W'(l) == LEVEL_BLACK) begin
               t[p][l] = PHASE_W'(pc);
            end else begin
               t[p][l] = PHASE_W'((pct * pc + DUTY_ROUND) / PERCENT_FULL);
            end
         end
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ptgd_front.sv =====
// Front end: takes request transfers, classifies pixels (range, address, duty, placement).
// Depends on ptgd_pkg.
`default_nettype none

module ptgd_front #(
   parameter int unsigned DisplayWidth  = ptgd_pkg::DISPLAY_WIDTH_DEF,
   parameter int unsigned DisplayHeight = ptgd_pkg::DISPLAY_HEIGHT_DEF,
   parameter int unsigned PhaseCount    = ptgd_pkg::PHASE_COUNT_DEF,
   parameter int unsigned EntryWidth    = 1
) (
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [ptgd_pkg::X_W-1:0]       req_pixel_x,
   input  wire logic [ptgd_pkg::Y_W-1:0]       req_pixel_y,
   input  wire logic [ptgd_pkg::LEVEL_W-1:0]   req_gray_level,
   input  wire logic [ptgd_pkg::PROFILE_W-1:0] curve_sel,
   input  wire logic                           queue_full,
   input  wire logic                           clear_busy,
   output      logic                           push,
   output      logic [EntryWidth-1:0]          push_entry
);

   localparam int unsigned AddrW = $clog2(DisplayWidth * DisplayHeight);
   localparam logic [AddrW-1:0] WIDTH_A = AddrW'(DisplayWidth);
   localparam logic [8:0] X_LIM = 9'(DisplayWidth);
   localparam logic [8:0] Y_LIM = 9'(DisplayHeight);
   localparam ptgd_pkg::duty_table_type DUTY_TABLE = ptgd_pkg::build_duty_table(PhaseCount);

   logic                            in_range;
   logic [AddrW-1:0]                addr;
   logic [ptgd_pkg::PHASE_W-1:0]    duty;
   ptgd_pkg::info_type              info;

   assign req_ready = !queue_full && !clear_busy;
   assign push      = req_valid && req_ready;

   always_comb begin
      in_range = (9'(req_pixel_x) < X_LIM) && (9'(req_pixel_y) < Y_LIM);
      addr     = AddrW'(req_pixel_y) * WIDTH_A + AddrW'(req_pixel_x);
      duty     = DUTY_TABLE[curve_sel][req_gray_level];
      info.to_status_line = req_pixel_y < ptgd_pkg::STATUS_ROWS;
      info.page_index     = info.to_status_line ? '0 : req_pixel_y[5:3] - 3'd1;
      info.bit_index      = req_pixel_y[2:0];
      info.column_out     = req_pixel_x;
   end

   assign push_entry = {addr, in_range, duty, info};

endmodule

`default_nettype wire

// ===== rtl/core/ptgd_queue.sv =====
// Two-entry queue between the front and back ends; push and pop in the same cycle.
// Depends on nothing but its width parameter.
`default_nettype none

module ptgd_queue #(
   parameter int unsigned EntryWidth = 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [EntryWidth-1:0] push_entry,
   input  wire logic                  pop,
   output      logic                  not_empty,
   output      logic                  full,
   output      logic [EntryWidth-1:0] head_entry
);

   logic [EntryWidth-1:0] slot_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;

   assign not_empty  = count_ff != 2'd0;
   assign full       = count_ff == 2'd2;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ptgd_back.sv =====
// Back end: seeds the accumulator memory after reset, then does the read-add-wrap-write
// per pixel with one-deep forwarding and drives the response register. Depends on ptgd_pkg.
`default_nettype none

module ptgd_back #(
   parameter int unsigned DisplayWidth  = ptgd_pkg::DISPLAY_WIDTH_DEF,
   parameter int unsigned DisplayHeight = ptgd_pkg::DISPLAY_HEIGHT_DEF,
   parameter int unsigned PhaseCount    = ptgd_pkg::PHASE_COUNT_DEF,
   parameter int unsigned EntryWidth    = 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         queue_not_empty,
   input  wire logic [EntryWidth-1:0]        head_entry,
   output      logic                         pop,
   output      logic                         clear_busy,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic                         rsp_pixel_on,
   output      logic                         rsp_to_status_line,
   output      logic [ptgd_pkg::PAGE_W-1:0]  rsp_page_index,
   output      logic [2:0]                   rsp_bit_index,
   output      logic [ptgd_pkg::X_W-1:0]     rsp_column_out
);

   localparam int unsigned Depth = DisplayWidth * DisplayHeight;
   localparam int unsigned AddrW = $clog2(Depth);
   localparam int unsigned XW    = $clog2(DisplayWidth);
   localparam int unsigned YW    = $clog2(DisplayHeight);
   localparam int unsigned PW    = ptgd_pkg::PHASE_W;
   localparam int unsigned InfoW = $bits(ptgd_pkg::info_type);
   localparam logic [PW:0]   PC_W   = (PW + 1)'(PhaseCount);
   localparam logic [PW-1:0] STEP_X = PW'(ptgd_pkg::SEED_X_MUL % PhaseCount);
   localparam logic [PW-1:0] STEP_Y = PW'(ptgd_pkg::SEED_Y_MUL % PhaseCount);
   localparam logic [PW-1:0] SEED_0 = PW'(ptgd_pkg::SEED_OFFSET % PhaseCount);
   localparam logic [XW-1:0] X_LAST = XW'(DisplayWidth - 1);
   localparam logic [YW-1:0] Y_LAST = YW'(DisplayHeight - 1);

   // seeding pass
   logic             clr_busy_ff, clr_busy_in;
   logic [XW-1:0]    clr_x_ff, clr_x_in;
   logic [YW-1:0]    clr_y_ff, clr_y_in;
   logic [AddrW-1:0] clr_addr_ff, clr_addr_in;
   logic [PW-1:0]    seed_ff, seed_in;
   logic [PW-1:0]    row_seed_ff, row_seed_in;
   logic [PW:0]      seed_sum, row_sum;
   logic [PW-1:0]    seed_wrap, row_wrap;

   // head of queue
   logic [AddrW-1:0]         q_addr;
   logic                     q_in_range;

   // execute stage
   logic                     b_valid_ff, b_valid_in;
   logic [EntryWidth-1:0]    b_entry_ff;
   logic                     b_fwd_ff, b_fwd_in;
   logic [PW-1:0]            rd_data_ff;
   logic [AddrW-1:0]         b_addr;
   logic                     b_in_range;
   logic [PW-1:0]            b_duty;
   ptgd_pkg::info_type       b_info;
   logic                     b_retire;
   logic                     b_write;
   logic [PW-1:0]            acc_old;
   logic [PW:0]              acc_sum;
   logic                     acc_carry;
   logic [PW-1:0]            acc_new;

   // last accumulator write
   logic [AddrW-1:0]         wr_addr_ff;
   logic [PW-1:0]            wr_data_ff;

   // memory port
   logic [PW-1:0]            acc_mem [Depth];
   logic                     mem_we;
   logic [AddrW-1:0]         mem_wa;
   logic [PW-1:0]            mem_wd;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_on_ff;
   ptgd_pkg::info_type       rsp_info_ff;

   assign clear_busy = clr_busy_ff;

   always_comb begin
      seed_sum  = {1'b0, seed_ff} + {1'b0, STEP_X};
      seed_wrap = (seed_sum >= PC_W) ? PW'(seed_sum - PC_W) : PW'(seed_sum);
      row_sum   = {1'b0, row_seed_ff} + {1'b0, STEP_Y};
      row_wrap  = (row_sum >= PC_W) ? PW'(row_sum - PC_W) : PW'(row_sum);

      clr_busy_in = clr_busy_ff;
      clr_x_in    = clr_x_ff;
      clr_y_in    = clr_y_ff;
      clr_addr_in = clr_addr_ff;
      seed_in     = seed_ff;
      row_seed_in = row_seed_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_x_ff == X_LAST) begin
            clr_x_in    = '0;
            clr_y_in    = clr_y_ff + 1'b1;
            row_seed_in = row_wrap;
            seed_in     = row_wrap;
            if (clr_y_ff == Y_LAST) begin
               clr_busy_in = 1'b0;
            end
         end else begin
            clr_x_in = clr_x_ff + 1'b1;
            seed_in  = seed_wrap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_x_ff    <= '0;
         clr_y_ff    <= '0;
         clr_addr_ff <= '0;
         seed_ff     <= SEED_0;
         row_seed_ff <= SEED_0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_x_ff    <= clr_x_in;
         clr_y_ff    <= clr_y_in;
         clr_addr_ff <= clr_addr_in;
         seed_ff     <= seed_in;
         row_seed_ff <= row_seed_in;
      end
   end

   always_comb begin
      q_addr     = head_entry[EntryWidth-1 -: AddrW];
      q_in_range = head_entry[PW + InfoW];
      b_addr     = b_entry_ff[EntryWidth-1 -: AddrW];
      b_in_range = b_entry_ff[PW + InfoW];
      b_duty     = b_entry_ff[InfoW +: PW];
      b_info     = b_entry_ff[InfoW-1:0];

      b_retire = b_valid_ff && (!rsp_valid_ff || rsp_ready);
      b_write  = b_retire && b_in_range;
      pop      = queue_not_empty && !clr_busy_ff && (!b_valid_ff || b_retire);
      b_fwd_in = b_write && q_in_range && (q_addr == b_addr);

      b_valid_in   = pop ? 1'b1 : (b_retire ? 1'b0 : b_valid_ff);
      rsp_valid_in = b_retire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      acc_old   = b_fwd_ff ? wr_data_ff : rd_data_ff;
      acc_sum   = {1'b0, acc_old} + {1'b0, b_duty};
      acc_carry = acc_sum >= PC_W;
      acc_new   = acc_carry ? PW'(acc_sum - PC_W) : PW'(acc_sum);

      mem_we = clr_busy_ff || b_write;
      mem_wa = clr_busy_ff ? clr_addr_ff : b_addr;
      mem_wd = clr_busy_ff ? seed_ff : acc_new;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         acc_mem[mem_wa] <= mem_wd;
      end
      if (pop) begin
         rd_data_ff <= acc_mem[q_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_entry_ff <= head_entry;
         b_fwd_ff   <= b_fwd_in;
      end
      if (b_write) begin
         wr_addr_ff <= b_addr;
         wr_data_ff <= acc_new;
      end
      if (b_retire) begin
         rsp_on_ff   <= b_in_range && acc_carry;
         rsp_info_ff <= b_info;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_on       = rsp_on_ff;
   assign rsp_to_status_line = rsp_info_ff.to_status_line;
   assign rsp_page_index     = rsp_info_ff.page_index;
   assign rsp_bit_index      = rsp_info_ff.bit_index;
   assign rsp_column_out     = rsp_info_ff.column_out;

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (!b_valid_ff && !rsp_valid_ff))
      else $error("pixel in flight during seeding pass");

   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      b_write |-> (acc_new < PW'(PhaseCount)))
      else $error("accumulator write out of phase range");

   a_fwd_match: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_fwd_ff) |-> (wr_addr_ff == b_addr))
      else $error("forwarded accumulator from another address");

   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      (pop && b_fwd_in) |=> (b_fwd_ff && $past(b_write)))
      else $error("forward flag without preceding write");

endmodule

`default_nettype wire

// ===== rtl/core/pixel_temporal_gray_dither.sv =====
// Top level of the temporal gray dither: CSR register, front end, queue, back end.
// Depends on ptgd_pkg, ptgd_front, ptgd_queue, ptgd_back.
//
// Usage:
//   req_*  : one pixel per transfer (column, row, 3-bit gray level).
//   rsp_*  : one result per pixel, in order: dark bit for this frame, status-line
//            flag, page, bit within page byte, column.
//   csr_*  : write of curve_sel (ready whenever reset is low); write only while no
//            pixel is outstanding.
// Throughput: one pixel per clock, while rsp_ready is high and seeding is done.
// Each pixel does one read of the accumulator memory, and an in-range pixel one
// write; back-to-back hits on the same pixel are forwarded from the previous write.
// Path: a request is written to a queue slot, popped with the memory read, then
// registered in the response register, which raises rsp_valid.
// Reset: curve_sel returns to the tuned curve and the accumulator memory is
// seeded with (7x + 11y + 3) mod PhaseCount, one entry per clock, all
// DisplayWidth * DisplayHeight entries (8192 by default), with req_ready low.
// Stall: the response register holds while rsp_ready is low; the two-entry queue
// absorbs requests, then req_ready drops.
`default_nettype none

module pixel_temporal_gray_dither #(
   parameter int unsigned DisplayWidth  = ptgd_pkg::DISPLAY_WIDTH_DEF,
   parameter int unsigned DisplayHeight = ptgd_pkg::DISPLAY_HEIGHT_DEF,
   parameter int unsigned PhaseCount    = ptgd_pkg::PHASE_COUNT_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [ptgd_pkg::X_W-1:0]       req_pixel_x,
   input  wire logic [ptgd_pkg::Y_W-1:0]       req_pixel_y,
   input  wire logic [ptgd_pkg::LEVEL_W-1:0]   req_gray_level,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic                           rsp_pixel_on,
   output      logic                           rsp_to_status_line,
   output      logic [ptgd_pkg::PAGE_W-1:0]    rsp_page_index,
   output      logic [2:0]                     rsp_bit_index,
   output      logic [ptgd_pkg::X_W-1:0]       rsp_column_out,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [ptgd_pkg::PROFILE_W-1:0] csr_curve_sel
);

   localparam int unsigned AddrW      = $clog2(DisplayWidth * DisplayHeight);
   localparam int unsigned EntryWidth = AddrW + 1 + ptgd_pkg::PHASE_W
                                        + $bits(ptgd_pkg::info_type);

   logic [ptgd_pkg::PROFILE_W-1:0] curve_sel_ff;
   logic                           push;
   logic [EntryWidth-1:0]          push_entry;
   logic                           pop;
   logic                           queue_not_empty;
   logic                           queue_full;
   logic [EntryWidth-1:0]          head_entry;
   logic                           clear_busy;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_sel_ff <= ptgd_pkg::PROFILE_TUNED;
      end else if (csr_valid && csr_ready) begin
         curve_sel_ff <= csr_curve_sel;
      end
   end

   ptgd_front #(
      .DisplayWidth  (DisplayWidth),
      .DisplayHeight (DisplayHeight),
      .PhaseCount    (PhaseCount),
      .EntryWidth    (EntryWidth)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .req_gray_level (req_gray_level),
      .curve_sel      (curve_sel_ff),
      .queue_full     (queue_full),
      .clear_busy     (clear_busy),
      .push           (push),
      .push_entry     (push_entry)
   );

   ptgd_queue #(
      .EntryWidth (EntryWidth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .full       (queue_full),
      .head_entry (head_entry)
   );

   ptgd_back #(
      .DisplayWidth  (DisplayWidth),
      .DisplayHeight (DisplayHeight),
      .PhaseCount    (PhaseCount),
      .EntryWidth    (EntryWidth)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_not_empty    (queue_not_empty),
      .head_entry         (head_entry),
      .pop                (pop),
      .clear_busy         (clear_busy),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_on       (rsp_pixel_on),
      .rsp_to_status_line (rsp_to_status_line),
      .rsp_page_index     (rsp_page_index),
      .rsp_bit_index      (rsp_bit_index),
      .rsp_column_out     (rsp_column_out)
   );

endmodule

`default_nettype wire
